// ----- design/kes_pkg.sv -----
`default_nettype none

package kes_pkg;

  // request codes, code 3 is unused and acts as a no-op
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_CHECK  = 2'd1,
    REQ_SIMPLE = 2'd2
  } kes_req_e;

  // configuration register indexes
  localparam logic CFG_LONG_PRESS = 1'b0;
  localparam logic CFG_REPEAT     = 1'b1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PinW     = 4;
  localparam int unsigned FlagW    = 6;

  localparam logic [CountW-1:0] LongPressReset = 16'd200;
  localparam logic [CountW-1:0] RepeatReset    = 16'd40;

  // event flag bit positions
  localparam int unsigned EvHold   = 0;
  localparam int unsigned EvDown   = 1;
  localparam int unsigned EvUp     = 2;
  localparam int unsigned EvSingle = 3;
  localparam int unsigned EvLong   = 4;
  localparam int unsigned EvRepeat = 5;

  localparam logic [FlagW-1:0] MaskHold   = 6'b00_0001;
  localparam logic [FlagW-1:0] MaskSingle = 6'b00_1000;

  typedef logic [FlagW-1:0] kes_flags_t;

  // per-key control from the top level
  typedef struct packed {
    logic       tick;
    logic       now;
    kes_flags_t clr;
  } kes_key_ctrl_t;

  // per-key status back to the top level
  typedef struct packed {
    logic       pressed;
    kes_flags_t flags;
  } kes_key_stat_t;

endpackage

`default_nettype wire

// ----- design/kes_channels.sv -----
`default_nettype none

interface kes_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] pin_levels;
  logic [1:0] key_index;
  logic [5:0] event_mask;

  modport source (output valid, req_type, pin_levels, key_index, event_mask, input ready);
  modport sink   (input valid, req_type, pin_levels, key_index, event_mask, output ready);
endinterface

interface kes_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] first_single_key;
  logic [3:0] held_keys;

  modport source (output valid, hit, first_single_key, held_keys, input ready);
  modport sink   (input valid, hit, first_single_key, held_keys, output ready);
endinterface

`default_nettype wire

// ----- design/kes_key.sv -----
`default_nettype none

module kes_key
  import kes_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kes_key_ctrl_t       ctrl_i,
  input  wire logic [CountW-1:0]   long_ticks_i,
  input  wire logic [CountW-1:0]   repeat_ticks_i,
  output kes_key_stat_t            stat_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              pressed_q, pressed_d;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_dec;
  kes_flags_t        flags_q, flags_d, f;

  assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

  always_comb begin
    phase_d   = phase_q;
    pressed_d = pressed_q;
    cnt_d     = cnt_q;
    f         = flags_q;
    if (ctrl_i.tick) begin
      cnt_d     = cnt_dec;
      pressed_d = ctrl_i.now;
      f[EvHold] = ctrl_i.now;
      if (ctrl_i.now && !pressed_q) f[EvDown] = 1'b1;
      if (!ctrl_i.now && pressed_q) f[EvUp] = 1'b1;
      unique case (phase_q)
        PH_PRESSED: begin
          if (!ctrl_i.now) begin
            f[EvSingle] = 1'b1;
            phase_d     = PH_IDLE;
          end else if (cnt_dec == '0) begin
            f[EvLong] = 1'b1;
            cnt_d     = repeat_ticks_i;
            phase_d   = PH_REPEAT;
          end
        end
        PH_REPEAT: begin
          if (!ctrl_i.now) begin
            phase_d = PH_IDLE;
          end else if (cnt_dec == '0) begin
            f[EvRepeat] = 1'b1;
            cnt_d       = repeat_ticks_i;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (ctrl_i.now) begin
            cnt_d   = long_ticks_i;
            phase_d = PH_PRESSED;
          end
        end
      endcase
    end
    flags_d = f & ~ctrl_i.clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pressed_q <= 1'b0;
      cnt_q     <= '0;
      flags_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pressed_q <= pressed_d;
      cnt_q     <= cnt_d;
      flags_q   <= flags_d;
    end
  end

  assign stat_o.pressed = pressed_q;
  assign stat_o.flags   = flags_q;

endmodule

`default_nettype wire

// ----- design/key_event_scanner.sv -----
// channel  | dir | payload                                          | handshake
// req_i    | in  | req_type, pin_levels, key_index, event_mask      | valid/ready
// rsp_o    | out | hit, first_single_key, held_keys                 | valid/ready
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | write enable
//
// one item per cycle sustained while rsp_o.ready stays high; an accepted request passes
// the request register and then the response register before rsp_o.valid rises
// key state is updated at the same edge the response register loads
// rst_ni clears key state and loads the default long press and repeat counts
// a stalled response holds the pipe; the request register still takes an item
// while the response waits, so both registers fill before req_i.ready drops
`default_nettype none

module key_event_scanner
  import kes_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  kes_req_if.sink                  req_i,
  kes_rsp_if.source                rsp_o
);

  // keys that have a pin and that the simple scan visits
  localparam int unsigned ScanKeys = (NUM_KEYS < PinW) ? NUM_KEYS : PinW;

  // configuration registers
  logic [CountW-1:0] long_ticks_q, repeat_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= LongPressReset;
      repeat_ticks_q <= RepeatReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS: long_ticks_q   <= cfg_wdata_i;
        CFG_REPEAT:     repeat_ticks_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // request register
  logic       in_vld_q;
  logic [1:0] req_type_q;
  logic [3:0] pins_q;
  logic [1:0] key_idx_q;
  kes_flags_t mask_q;

  // response register
  logic       out_vld_q;
  logic       hit_q, hit_d;
  logic [2:0] first_q, first_d;
  logic [3:0] held_q, held_d;

  logic advance, req_acc;

  // request moves into the response register when that one is free or drains
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign req_acc     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q <= req_i.req_type;
      pins_q     <= req_i.pin_levels;
      key_idx_q  <= req_i.key_index;
      mask_q     <= req_i.event_mask;
    end
    if (advance) begin
      hit_q   <= hit_d;
      first_q <= first_d;
      held_q  <= held_d;
    end
  end

  // request decode
  logic is_tick, is_check, is_simple;

  always_comb begin
    is_tick   = 1'b0;
    is_check  = 1'b0;
    is_simple = 1'b0;
    unique case (kes_req_e'(req_type_q))
      REQ_TICK:   is_tick   = 1'b1;
      REQ_CHECK:  is_check  = 1'b1;
      REQ_SIMPLE: is_simple = 1'b1;
      default:    ;
    endcase
  end

  // per-key lanes
  kes_key_stat_t       stat  [NUM_KEYS];
  kes_key_ctrl_t       ctrl  [NUM_KEYS];
  logic [NUM_KEYS-1:0] now_vec;
  logic [NUM_KEYS-1:0] hit_vec;
  logic [PinW-1:0]     single_vec, pressed_vec, now_pin_vec;

  // hold alone is only peeked at, never consumed
  logic       chk_consume;
  kes_flags_t chk_clr;
  assign chk_consume = is_check && (mask_q != MaskHold);
  assign chk_clr     = chk_consume ? mask_q : '0;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic sel, simple_clr;

    // keys without a pin read as released
    if (k < PinW) begin : g_pin
      assign now_vec[k] = !pins_q[k];
      assign sel        = (key_idx_q == 2'(k));
      assign simple_clr = is_simple && (first_d == 3'(k + 1));
    end else begin : g_nopin
      assign now_vec[k] = 1'b0;
      assign sel        = 1'b0;
      assign simple_clr = 1'b0;
    end

    assign hit_vec[k] = sel && ((stat[k].flags & mask_q) != '0);

    always_comb begin
      ctrl[k].tick = advance && is_tick;
      ctrl[k].now  = now_vec[k];
      ctrl[k].clr  = '0;
      if (advance && sel) ctrl[k].clr = chk_clr;
      if (advance && simple_clr) ctrl[k].clr = MaskSingle;
    end

    kes_key u_key (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl[k]),
      .long_ticks_i   (long_ticks_q),
      .repeat_ticks_i (repeat_ticks_q),
      .stat_o         (stat[k])
    );
  end

  for (genvar k = 0; k < PinW; k++) begin : g_scan
    if (k < ScanKeys) begin : g_on
      assign single_vec[k]  = stat[k].flags[EvSingle];
      assign pressed_vec[k] = stat[k].pressed;
      assign now_pin_vec[k] = now_vec[k];
    end else begin : g_off
      assign single_vec[k]  = 1'b0;
      assign pressed_vec[k] = 1'b0;
      assign now_pin_vec[k] = 1'b0;
    end
  end

  // lowest pending single click, numbered from one
  logic found;

  always_comb begin
    found   = 1'b0;
    first_d = '0;
    if (is_simple) begin
      for (int unsigned k = 0; k < PinW; k++) begin
        if (!found && single_vec[k]) begin
          found   = 1'b1;
          first_d = 3'(k + 1);
        end
      end
    end
  end

  assign hit_d  = is_check && (|hit_vec);
  // held map reflects the sample taken by this item when it is a tick
  assign held_d = is_tick ? now_pin_vec : pressed_vec;

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.hit              = hit_q;
  assign rsp_o.first_single_key = first_q;
  assign rsp_o.held_keys        = held_q;

endmodule

`default_nettype wire
